/* hdl/dmif_pkg.sv */
package dmif_pkg;

  // fixed field widths
  localparam int ID_W    = 16;
  localparam int CFG_W   = 5;
  localparam int KOUT_W  = 5;
  localparam int CNT_W   = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // per-item command passed from the front to the back
  typedef struct packed {
    logic [ID_W-1:0] row;   // row id of the open row
    logic [ID_W-1:0] prev;  // clamped id of the previous neighbor
    logic [ID_W-1:0] nb;    // clamped id of this neighbor
    logic            first; // first item of a row: counters start from zero
    logic            last;  // last item of a row: counters cleared after
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

/* hdl/dyadic_majority_interval_finder.sv */
// Channel  Dir  Handshake                  Payload
// s        in   s_tvalid / s_tready        s_tdata: row_id, neighbor; s_tlast: last_in_row
// m        out  m_tvalid / m_tready        m_tdata: out_row_id, interval_start,
//                                          interval_size_log2; m_tlast: last_result
// cfg      in   cfg_valid / cfg_ready      cfg_data: level_count
//
// The back end drains an item's results one per cycle through the output register
// while the output is not stalled; a neighbor closes about two intervals.
// The front takes an item every cycle while the four-entry command queue has room.
// Reset (rst, synchronous) clears the counters, queue and row state.
// Output stalls back up into the queue; cfg_ready is always high.
module dyadic_majority_interval_finder #(
  parameter int MAX_LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] row_id, [31:16] neighbor
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] out_row_id, [31:16] interval_start,
                                 // [36:32] interval_size_log2, [39:37] zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int QW = dmif_pkg::CMD_W + 2 * (MAX_LEVELS + 1);

  dmif_pkg::cmd_t              f_cmd;
  logic [MAX_LEVELS:0]         f_close;
  logic [MAX_LEVELS:0]         f_end;
  logic                        f_valid;
  logic                        f_ready;
  logic [QW-1:0]               q_out;
  logic                        q_valid;
  logic                        q_ready;
  dmif_pkg::cmd_t              b_cmd;
  logic [MAX_LEVELS:0]         b_close;
  logic [MAX_LEVELS:0]         b_end;
  logic [dmif_pkg::ID_W-1:0]   res_row;
  logic [dmif_pkg::ID_W-1:0]   res_start;
  logic [dmif_pkg::KOUT_W-1:0] res_k;

  assign cfg_ready = 1'b1;

  dmif_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .row_id      (s_tdata[15:0]),
    .neighbor    (s_tdata[31:16]),
    .last_in_row (s_tlast),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd),
    .close_mask  (f_close),
    .end_mask    (f_end)
  );

  dmif_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_end, f_close, f_cmd}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_out)
  );

  // unpack queue entry
  assign b_cmd   = q_out[dmif_pkg::CMD_W-1:0];
  assign b_close = q_out[dmif_pkg::CMD_W +: MAX_LEVELS + 1];
  assign b_end   = q_out[dmif_pkg::CMD_W + MAX_LEVELS + 1 +: MAX_LEVELS + 1];

  dmif_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (q_valid),
    .cmd_ready          (q_ready),
    .cmd                (b_cmd),
    .close_mask         (b_close),
    .end_mask           (b_end),
    .res_valid          (m_tvalid),
    .res_ready          (m_tready),
    .out_row_id         (res_row),
    .interval_start     (res_start),
    .interval_size_log2 (res_k),
    .last_result        (m_tlast)
  );

  assign m_tdata = {3'b000, res_k, res_start, res_row};

endmodule

/* hdl/dmif_front.sv */
module dmif_front #(
  parameter int MAX_LEVELS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // config write
  input  logic                        cfg_we,
  input  logic [dmif_pkg::CFG_W-1:0]  cfg_data,
  // input item
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dmif_pkg::ID_W-1:0]   row_id,
  input  logic [dmif_pkg::ID_W-1:0]   neighbor,
  input  logic                        last_in_row,
  // command out to the queue
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output dmif_pkg::cmd_t              cmd,
  output logic [MAX_LEVELS:0]         close_mask,
  output logic [MAX_LEVELS:0]         end_mask
);

  localparam int LVW_RAW = $clog2(MAX_LEVELS + 1);
  localparam int LVW     = (LVW_RAW > dmif_pkg::CFG_W) ? LVW_RAW : dmif_pkg::CFG_W;

  logic [dmif_pkg::CFG_W-1:0] level_count;
  logic [dmif_pkg::ID_W-1:0]  previous_neighbor;
  logic                       row_open;
  logic [dmif_pkg::ID_W-1:0]  open_row_id;

  logic [LVW-1:0]             cfg_ext;
  logic [LVW-1:0]             levels;
  logic [dmif_pkg::ID_W:0]    top_wide;
  logic [dmif_pkg::ID_W-1:0]  top;
  logic [dmif_pkg::ID_W-1:0]  nb;
  logic                       accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  // effective level count and the top id of the space
  always_comb begin
    cfg_ext  = LVW'(level_count);
    levels   = (cfg_ext > LVW'(MAX_LEVELS)) ? LVW'(MAX_LEVELS) : cfg_ext;
    top_wide = ((dmif_pkg::ID_W + 1)'(1) << levels) - (dmif_pkg::ID_W + 1)'(1);
    top      = top_wide[dmif_pkg::ID_W-1:0];
    nb       = (neighbor > top) ? top : neighbor;
  end

  // classify: which levels close mid-row, which close at row end
  always_comb begin
    for (int k = 0; k <= MAX_LEVELS; k++) begin
      close_mask[k] = row_open && (k < int'(levels)) &&
                      ((nb >> k) != (previous_neighbor >> k));
      end_mask[k]   = last_in_row && (k <= int'(levels));
    end
    cmd.row   = row_open ? open_row_id : row_id;
    cmd.prev  = previous_neighbor;
    cmd.nb    = nb;
    cmd.first = !row_open;
    cmd.last  = last_in_row;
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= '0;
    end else if (cfg_we) begin
      level_count <= cfg_data;
    end
  end

  // row tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_neighbor <= '0;
      row_open          <= 1'b0;
      open_row_id       <= '0;
    end else if (accept) begin
      if (!row_open) begin
        open_row_id <= row_id;
      end
      row_open          <= !last_in_row;
      previous_neighbor <= last_in_row ? '0 : nb;
    end
  end

endmodule

/* hdl/dmif_queue.sv */
module dmif_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != (AW + 1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/dmif_back.sv */
module dmif_back #(
  parameter int MAX_LEVELS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // command from the queue
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  dmif_pkg::cmd_t              cmd,
  input  logic [MAX_LEVELS:0]         close_mask,
  input  logic [MAX_LEVELS:0]         end_mask,
  // result out
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [dmif_pkg::ID_W-1:0]   out_row_id,
  output logic [dmif_pkg::ID_W-1:0]   interval_start,
  output logic [dmif_pkg::KOUT_W-1:0] interval_size_log2,
  output logic                        last_result
);

  localparam int NL   = MAX_LEVELS + 1;
  localparam int SELW = $clog2(2 * NL);
  localparam int KW   = (NL > 1) ? $clog2(NL) : 1;
  // compare width for 2*c > 2^k
  localparam int MW_A = dmif_pkg::CNT_W + 2;
  localparam int MW_B = MAX_LEVELS + 2;
  localparam int MW   = (MW_A > MW_B) ? MW_A : MW_B;

  logic [dmif_pkg::CNT_W-1:0] level_counts [NL];

  // current item being drained
  logic [2*NL-1:0]            pend;
  logic [dmif_pkg::ID_W-1:0]  cur_row;
  logic [dmif_pkg::ID_W-1:0]  cur_prev;
  logic [dmif_pkg::ID_W-1:0]  cur_nb;

  logic [dmif_pkg::CNT_W-1:0] eff   [NL];
  logic [dmif_pkg::CNT_W-1:0] inc   [NL];
  logic [NL-1:0]              maj_a;
  logic [NL-1:0]              maj_b;

  logic                       out_free;
  logic                       pick;
  logic [SELW-1:0]            sel;
  logic [2*NL-1:0]            pick_oh;
  logic [2*NL-1:0]            rem;
  logic                       load;
  logic [KW-1:0]              sel_k;
  logic [dmif_pkg::ID_W-1:0]  sel_id;

  // majority of an interval of 2^k ids
  function automatic logic is_major(logic [dmif_pkg::CNT_W-1:0] c, int k);
    logic [MW-1:0] twice;
    logic [MW-1:0] size;
    twice = MW'(c) << 1;
    size  = MW'(1) << k;
    return (c != '0) && (twice > size);
  endfunction

  // counters after the mid-row closes and the increment, plus both result masks
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      eff[k]   = cmd.first ? '0 : level_counts[k];
      maj_a[k] = close_mask[k] && is_major(eff[k], k);
      if (close_mask[k]) begin
        inc[k] = dmif_pkg::CNT_W'(1);
      end else if (eff[k] == dmif_pkg::CNT_MAX) begin
        inc[k] = eff[k];
      end else begin
        inc[k] = eff[k] + dmif_pkg::CNT_W'(1);
      end
      maj_b[k] = end_mask[k] && is_major(inc[k], k);
    end
  end

  // lowest pending result: mid-row closes first, then row-end closes
  always_comb begin
    sel = '0;
    for (int i = 2 * NL - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SELW'(i);
      end
    end
    pick_oh  = pend & (~pend + (2 * NL)'(1));
    out_free = !res_valid || res_ready;
    pick     = out_free && (pend != '0);
    rem      = pick ? (pend & ~pick_oh) : pend;
    load     = cmd_valid && (rem == '0);
    if (int'(sel) < NL) begin
      sel_k  = KW'(sel);
      sel_id = cur_prev;
    end else begin
      sel_k  = KW'(int'(sel) - NL);
      sel_id = cur_nb;
    end
  end

  assign cmd_ready = load;

  // item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= {maj_b, maj_a};
    end else begin
      pend <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_row  <= cmd.row;
      cur_prev <= cmd.prev;
      cur_nb   <= cmd.nb;
    end
  end

  // level counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NL; k++) begin
        level_counts[k] <= '0;
      end
    end else if (load) begin
      for (int k = 0; k < NL; k++) begin
        level_counts[k] <= cmd.last ? '0 : inc[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      out_row_id         <= cur_row;
      interval_start     <= sel_id & (dmif_pkg::ID_W'({dmif_pkg::ID_W{1'b1}}) << sel_k);
      interval_size_log2 <= dmif_pkg::KOUT_W'(sel_k);
      last_result        <= (rem == '0);
    end
  end

endmodule
